// ===== hw/rtl/scff_pkg.sv =====
`timescale 1ns / 1ps
package scff_pkg;

  localparam int ANGLE_BITS_DEF    = 24;
  localparam int FLUX_BITS_DEF     = 48;
  localparam int CORDIC_STAGES_DEF = 24;

  // Q1.22 datapath widths
  localparam int QW  = 28;  // CORDIC x/y
  localparam int ZW  = 34;  // CORDIC angle, 2^-32 turn units
  localparam int CW  = 24;  // clamped sin/cos/dot
  localparam int PW  = 48;  // products
  localparam int SQW = 46;  // square-root remainder and root
  localparam int SQ_STEPS = 23;

  localparam logic signed [QW-1:0] Q_ONE    = QW'(4194304);
  localparam logic signed [QW-1:0] INV_GAIN = QW'(2547003);

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CENTER_RA     = 3'd0;
  localparam cfg_idx_t REG_CENTER_DEC    = 3'd1;
  localparam cfg_idx_t REG_SEARCH_RADIUS = 3'd2;
  localparam cfg_idx_t REG_FLUX_MIN      = 3'd3;
  localparam cfg_idx_t REG_FLUX_MAX      = 3'd4;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] r;
  } sqrt_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return signed'(ZW'(a));
  endfunction

  function automatic logic signed [PW-1:0] round22(input logic signed [PW-1:0] v);
    return (v + PW'(64'sd2097152)) >>> 22;
  endfunction

  function automatic logic signed [CW-1:0] clamp_one(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v;
    if (v > PW'(Q_ONE)) r = PW'(Q_ONE);
    if (v < -PW'(Q_ONE)) r = -PW'(Q_ONE);
    return r[CW-1:0];
  endfunction

endpackage

// ===== hw/rtl/scff_in_if.sv =====
`timescale 1ns / 1ps
interface scff_in_if #(
  parameter int ANGLE_BITS = scff_pkg::ANGLE_BITS_DEF,
  parameter int FLUX_BITS  = scff_pkg::FLUX_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic        [ANGLE_BITS-1:0] source_ra;
  logic signed [ANGLE_BITS-1:0] source_dec;
  logic        [FLUX_BITS-1:0]  peak_flux;

  modport source (output valid, source_ra, source_dec, peak_flux, input ready);
  modport sink   (input valid, source_ra, source_dec, peak_flux, output ready);
endinterface

// ===== hw/rtl/scff_out_if.sv =====
`timescale 1ns / 1ps
interface scff_out_if #(
  parameter int ANGLE_BITS = scff_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  in_cone;
  logic                  flux_ok;
  logic [ANGLE_BITS-1:0] separation;

  modport source (output valid, in_cone, flux_ok, separation, input ready);
  modport sink   (input valid, in_cone, flux_ok, separation, output ready);
endinterface

// ===== hw/rtl/scff_rot_cell.sv =====
`timescale 1ns / 1ps
// one rotation-mode CORDIC micro-rotation, registered
module scff_rot_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  scff_pkg::cordic_t d_in,
  input  logic [1:0]        q_in,
  output scff_pkg::cordic_t d_out,
  output logic [1:0]        q_out
);
  scff_pkg::cordic_t d_nxt;
  logic signed [scff_pkg::QW-1:0] dx, dy;

  always_comb begin
    dx = d_in.y >>> IDX;
    dy = d_in.x >>> IDX;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - scff_pkg::atan_turn(IDX);
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + scff_pkg::atan_turn(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_nxt;
      q_out <= q_in;
    end
  end
endmodule

// ===== hw/rtl/scff_sqrt_cell.sv =====
`timescale 1ns / 1ps
// one bit of a restoring integer square root, registered
module scff_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  scff_pkg::sqrt_t                d_in,
  input  logic signed [scff_pkg::CW-1:0] dot_in,
  output scff_pkg::sqrt_t                d_out,
  output logic signed [scff_pkg::CW-1:0] dot_out
);
  localparam logic [scff_pkg::SQW-1:0] BIT =
    scff_pkg::SQW'(1) << (2 * (scff_pkg::SQ_STEPS - 1 - K));

  scff_pkg::sqrt_t d_nxt;
  logic [scff_pkg::SQW-1:0] trial;

  always_comb begin
    trial = d_in.r + BIT;
    if (d_in.v >= trial) begin
      d_nxt.v = d_in.v - trial;
      d_nxt.r = (d_in.r >> 1) + BIT;
    end else begin
      d_nxt.v = d_in.v;
      d_nxt.r = d_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out   <= d_nxt;
      dot_out <= dot_in;
    end
  end
endmodule

// ===== hw/rtl/scff_vec_cell.sv =====
`timescale 1ns / 1ps
// one vectoring-mode CORDIC micro-rotation, registered
module scff_vec_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              en,
  input  scff_pkg::cordic_t d_in,
  output scff_pkg::cordic_t d_out
);
  scff_pkg::cordic_t d_nxt;
  logic signed [scff_pkg::QW-1:0] dx, dy;

  always_comb begin
    dx = d_in.y >>> IDX;
    dy = d_in.x >>> IDX;
    if (d_in.y >= 0) begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + scff_pkg::atan_turn(IDX);
    end else begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - scff_pkg::atan_turn(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= d_nxt;
  end
endmodule

// ===== hw/rtl/sky_cone_flux_filter_top.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_req    in   valid/ready    source_ra, source_dec, peak_flux
// out_res   out  valid/ready    in_cone, flux_ok, separation
// cfg_*     in   cfg_we         cfg_idx, cfg_data
//
// One request per cycle while the output register is not stalled; the path runs through two CORDIC cell
// chains (sin/cos, then acos) with the 23-cell square-root chain between them.
// Synchronous active-low reset clears the valid pipeline and the config registers, but sets flux max to all ones.
// The whole pipeline stalls together while a result waits in the output register.
module sky_cone_flux_filter_top #(
  parameter int ANGLE_BITS    = scff_pkg::ANGLE_BITS_DEF,
  parameter int FLUX_BITS     = scff_pkg::FLUX_BITS_DEF,
  parameter int CORDIC_STAGES = scff_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  scff_in_if.sink    in_req,
  scff_out_if.source out_res,
  input  logic                           cfg_we,
  input  scff_pkg::cfg_idx_t             cfg_idx,
  input  logic [((ANGLE_BITS > FLUX_BITS) ? ANGLE_BITS : FLUX_BITS)-1:0] cfg_data
);
  localparam int QW  = scff_pkg::QW;
  localparam int ZW  = scff_pkg::ZW;
  localparam int CW  = scff_pkg::CW;
  localparam int PW  = scff_pkg::PW;
  localparam int SQW = scff_pkg::SQW;
  localparam int SQ  = scff_pkg::SQ_STEPS;
  localparam int N   = CORDIC_STAGES;
  localparam int SH  = 32 - ANGLE_BITS;
  localparam int LAT = 2 * N + 9 + SQ;

  // configuration
  logic        [ANGLE_BITS-1:0] center_ra_r, center_dec_r, radius_r;
  logic        [FLUX_BITS-1:0]  flux_min_r, flux_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_ra_r  <= '0;
      center_dec_r <= '0;
      radius_r     <= '0;
      flux_min_r   <= '0;
      flux_max_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        scff_pkg::REG_CENTER_RA:     center_ra_r  <= cfg_data[ANGLE_BITS-1:0];
        scff_pkg::REG_CENTER_DEC:    center_dec_r <= cfg_data[ANGLE_BITS-1:0];
        scff_pkg::REG_SEARCH_RADIUS: radius_r     <= cfg_data[ANGLE_BITS-1:0];
        scff_pkg::REG_FLUX_MIN:      flux_min_r   <= cfg_data[FLUX_BITS-1:0];
        scff_pkg::REG_FLUX_MAX:      flux_max_r   <= cfg_data[FLUX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [LAT-1:0] fok_r, fok_nxt;
  logic           adv, in_fire, fok_in;

  assign adv          = !vld_r[LAT-1] || out_res.ready;
  assign in_req.ready = adv;
  assign in_fire      = in_req.valid && adv;
  assign fok_in       = (in_req.peak_flux >= flux_min_r) && (in_req.peak_flux <= flux_max_r);
  assign vld_nxt      = {vld_r[LAT-2:0], in_fire};
  assign fok_nxt      = {fok_r[LAT-2:0], fok_in};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) fok_r <= fok_nxt;
  end

  // four sin/cos lanes: center ra, center dec, source ra, source dec
  scff_pkg::cordic_t rc [4][N+1];
  logic [1:0]        qc [4][N+1];
  logic signed [CW-1:0] cosv [4];
  logic signed [CW-1:0] sinv [4];
  logic signed [CW-1:0] cos_r [4];
  logic signed [CW-1:0] sin_r [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [ANGLE_BITS-1:0] ang, u;
    logic [ZW-1:0]         zu;
    scff_pkg::cordic_t     init;
    logic signed [QW-1:0]  xe, ye, cq, sq;

    always_comb begin
      case (l)
        0:       ang = center_ra_r;
        1:       ang = center_dec_r;
        2:       ang = in_req.source_ra;
        default: ang = in_req.source_dec;
      endcase
      // shift to octant around the quadrant center
      u      = ang + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
      zu     = ZW'(u[ANGLE_BITS-3:0]) << SH;
      init.x = scff_pkg::INV_GAIN;
      init.y = '0;
      init.z = signed'(zu) - (ZW'(1) << 29);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rc[l][0] <= init;
        qc[l][0] <= u[ANGLE_BITS-1:ANGLE_BITS-2];
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
      scff_rot_cell #(.IDX(i)) u_cell (
        .clk  (clk),
        .en   (adv),
        .d_in (rc[l][i]),
        .q_in (qc[l][i]),
        .d_out(rc[l][i+1]),
        .q_out(qc[l][i+1])
      );
    end

    always_comb begin
      xe = rc[l][N].x;
      ye = rc[l][N].y;
      case (qc[l][N])
        2'd0:    begin cq = xe;  sq = ye;  end
        2'd1:    begin cq = -ye; sq = xe;  end
        2'd2:    begin cq = -xe; sq = -ye; end
        default: begin cq = ye;  sq = -xe; end
      endcase
      cosv[l] = scff_pkg::clamp_one(PW'(cq));
      sinv[l] = scff_pkg::clamp_one(PW'(sq));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cos_r[l] <= cosv[l];
        sin_r[l] <= sinv[l];
      end
    end
  end

  // dot product: d = round(round(cd1*cd2) * round(cr1*cr2 + sr1*sr2) + sd1*sd2)
  logic signed [PW-1:0] cdcd_r, crcr_r, srsr_r, sdsd1_r;
  logic signed [PW-1:0] sdsd2_r, tp_r, sdsd3_r;
  logic signed [CW-1:0] t_r;
  logic signed [CW:0]   p_r;   // cos of the ra difference, up to two units before rounding
  logic signed [CW-1:0] d_r, d5_r;
  logic [SQW-1:0]       rad_r;
  logic signed [PW-1:0] dd;

  assign dd = PW'(d_r) * PW'(d_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      cdcd_r  <= PW'(cos_r[1]) * PW'(cos_r[3]);
      crcr_r  <= PW'(cos_r[0]) * PW'(cos_r[2]);
      srsr_r  <= PW'(sin_r[0]) * PW'(sin_r[2]);
      sdsd1_r <= PW'(sin_r[1]) * PW'(sin_r[3]);
      t_r     <= CW'(scff_pkg::round22(cdcd_r));
      p_r     <= (CW+1)'(scff_pkg::round22(crcr_r + srsr_r));
      sdsd2_r <= sdsd1_r;
      tp_r    <= PW'(t_r) * PW'(p_r);
      sdsd3_r <= sdsd2_r;
      d_r     <= scff_pkg::clamp_one(scff_pkg::round22(tp_r + sdsd3_r));
      rad_r   <= (SQW'(1) << 44) - SQW'(dd);
      d5_r    <= d_r;
    end
  end

  // sqrt(1 - d^2)
  scff_pkg::sqrt_t      sc [SQ+1];
  logic signed [CW-1:0] dc [SQ+1];

  assign sc[0].v = rad_r;
  assign sc[0].r = '0;
  assign dc[0]   = d5_r;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    scff_sqrt_cell #(.K(k)) u_cell (
      .clk    (clk),
      .en     (adv),
      .d_in   (sc[k]),
      .dot_in (dc[k]),
      .d_out  (sc[k+1]),
      .dot_out(dc[k+1])
    );
  end

  // acos via vectoring CORDIC
  scff_pkg::cordic_t    vc [N+1];
  scff_pkg::cordic_t    vinit;
  logic signed [QW-1:0] s_q, d_q;

  always_comb begin
    s_q = signed'(QW'(sc[SQ].r));
    d_q = QW'(dc[SQ]);
    if (dc[SQ] < 0) begin
      vinit.x = s_q;
      vinit.y = -d_q;
      vinit.z = ZW'(1) << 30;
    end else begin
      vinit.x = d_q;
      vinit.y = s_q;
      vinit.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) vc[0] <= vinit;
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    scff_vec_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .en   (adv),
      .d_in (vc[i]),
      .d_out(vc[i+1])
    );
  end

  // rounding to the output angle and the cone test
  logic [ZW-1:0] zc, zr, zs;
  logic [ANGLE_BITS-1:0] sep;
  logic                  fok_out;
  logic                  in_cone_r, flux_ok_r;
  logic [ANGLE_BITS-1:0] sep_r;

  assign zc = (vc[N].z < 0) ? '0 : vc[N].z;

  if (SH > 0) begin : g_rnd
    assign zr = (zc + (ZW'(1) << (SH - 1))) >> SH;
  end else begin : g_nornd
    assign zr = zc;
  end

  assign zs      = (zr > (ZW'(1) << (ANGLE_BITS - 1))) ? (ZW'(1) << (ANGLE_BITS - 1)) : zr;
  assign sep     = zs[ANGLE_BITS-1:0];
  assign fok_out = fok_r[LAT-2];

  always_ff @(posedge clk) begin
    if (adv) begin
      flux_ok_r <= fok_out;
      in_cone_r <= fok_out && (sep <= radius_r);
      sep_r     <= fok_out ? sep : '0;
    end
  end

  assign out_res.valid      = vld_r[LAT-1];
  assign out_res.in_cone    = in_cone_r;
  assign out_res.flux_ok    = flux_ok_r;
  assign out_res.separation = sep_r;
endmodule

// ===== dv/tb_sky_cone_flux_filter_top.sv =====
`timescale 1ns / 1ps
module tb_sky_cone_flux_filter_top;

  localparam int  LATENCY     = 2 * scff_pkg::CORDIC_STAGES_DEF + 32;
  localparam int  CYCLE_LIMIT = 400000;
  localparam longint QONE     = 64'sd4194304;
  localparam logic [23:0] DEC_MAX = 24'h400000;
  localparam logic [23:0] DEC_MIN = 24'hc00000;
  localparam logic [47:0] FLUX_ALL = 48'hffff_ffff_ffff;

  typedef struct packed {
    logic        in_cone;
    logic        flux_ok;
    logic [23:0] separation;
  } cone_result_t;

  // CORDIC arctangents in 2^-32 turn units
  localparam longint ARCTAN [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic clk;
  logic rst_n;
  logic               cfg_we;
  scff_pkg::cfg_idx_t cfg_idx;
  logic [47:0]        cfg_data;

  scff_in_if  in_req ();
  scff_out_if out_res ();

  sky_cone_flux_filter_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // shadow copy of the registers
  logic [23:0] ctr_ra, ctr_dec, radius;
  logic [47:0] flux_lo, flux_hi;

  cone_result_t pending_q[$];
  int errors;
  int cycles;
  int burst_left;
  int hold_left;
  int rx_mode;
  int rx_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic longint sat_unit(input longint v);
    if (v > QONE) return QONE;
    if (v < -QONE) return -QONE;
    return v;
  endfunction

  function automatic longint rnd22(input longint v);
    return (v + 64'sd2097152) >>> 22;
  endfunction

  function automatic void turn_sincos(input logic [23:0] a, output longint c, output longint s);
    logic [23:0] u;
    logic [1:0]  q;
    longint x, y, z, dx, dy;
    u = a + 24'h200000;
    q = u[23:22];
    z = longint'({u[21:0], 8'b0}) - (64'sd1 <<< 29);
    x = 2547003;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = sat_unit(c);
    s = sat_unit(s);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] dot_to_angle(input longint d);
    longint s, x, y, z, dx, dy;
    longint unsigned r;
    s = longint'(int_sqrt(longint'(QONE * QONE - d * d)));
    if (d < 0) begin
      x = s; y = -d; z = 64'sd1 <<< 30;
    end else begin
      x = d; y = s; z = 0;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    if (z < 0) z = 0;
    r = (longint'(z) + 128) >> 8;
    if (r > 64'd8388608) r = 64'd8388608;
    return r[23:0];
  endfunction

  function automatic cone_result_t predict_cone(input logic [23:0] ra, input logic [23:0] dec,
                                                input logic [47:0] flux);
    cone_result_t res;
    longint cr1, sr1, cd1, sd1, cr2, sr2, cd2, sd2, t, p, d;
    res = '0;
    if (flux < flux_lo || flux > flux_hi) return res;
    turn_sincos(ctr_ra, cr1, sr1);
    turn_sincos(ctr_dec, cd1, sd1);
    turn_sincos(ra, cr2, sr2);
    turn_sincos(dec, cd2, sd2);
    t = rnd22(cd1 * cd2);
    p = rnd22(cr1 * cr2 + sr1 * sr2);
    d = sat_unit(rnd22(t * p + sd1 * sd2));
    res.separation = dot_to_angle(d);
    res.flux_ok    = 1'b1;
    res.in_cone    = (res.separation <= radius);
    return res;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      rx_tick <= 0;
      rx_mode <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 50 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_res.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_res.ready <= 1'b1;
          1: out_res.ready <= 1'($urandom_range(0, 1));
          default: out_res.ready <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cone_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: in_cone %0b flux_ok %0b separation %h",
                 $time, out_res.in_cone, out_res.flux_ok, out_res.separation);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_res.in_cone !== want.in_cone) begin
          $display("%0t in_cone: expected %0b actual %0b", $time, want.in_cone, out_res.in_cone);
          errors++;
        end
        if (out_res.flux_ok !== want.flux_ok) begin
          $display("%0t flux_ok: expected %0b actual %0b", $time, want.flux_ok, out_res.flux_ok);
          errors++;
        end
        if (out_res.separation !== want.separation) begin
          $display("%0t separation: expected %h actual %h", $time, want.separation,
                   out_res.separation);
          errors++;
        end
      end
    end
  end

  // ---------------- request side ----------------
  task automatic send_source(input logic [23:0] ra, input logic [23:0] dec,
                             input logic [47:0] flux);
    cone_result_t want;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    want = predict_cone(ra, dec, flux);
    in_req.valid      <= 1'b1;
    in_req.source_ra  <= ra;
    in_req.source_dec <= dec;
    in_req.peak_flux  <= flux;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    pending_q = {pending_q, want};
  endtask

  task automatic drain;
    in_req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input scff_pkg::cfg_idx_t idx, input logic [47:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      scff_pkg::REG_CENTER_RA:     ctr_ra  = val[23:0];
      scff_pkg::REG_CENTER_DEC:    ctr_dec = val[23:0];
      scff_pkg::REG_SEARCH_RADIUS: radius  = val[23:0];
      scff_pkg::REG_FLUX_MIN:      flux_lo = val;
      scff_pkg::REG_FLUX_MAX:      flux_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_search(input logic [23:0] ra, input logic [23:0] dec,
                            input logic [23:0] rad, input logic [47:0] lo,
                            input logic [47:0] hi);
    drain();
    write_reg(scff_pkg::REG_CENTER_RA, {24'b0, ra});
    write_reg(scff_pkg::REG_CENTER_DEC, {24'b0, dec});
    write_reg(scff_pkg::REG_SEARCH_RADIUS, {24'b0, rad});
    write_reg(scff_pkg::REG_FLUX_MIN, lo);
    write_reg(scff_pkg::REG_FLUX_MAX, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_dec();
    if ($urandom_range(0, 7) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 8388608) - 4194304);
  endfunction

  function automatic logic [47:0] rand_flux();
    logic [47:0] f;
    if (flux_lo <= flux_hi && $urandom_range(0, 3) != 0) begin
      f = 48'({$urandom, $urandom});
      // window span taken one bit wider so a full window does not wrap to zero
      return 48'(flux_lo + f % ({1'b0, flux_hi - flux_lo} + 49'd1));
    end
    return 48'({$urandom, $urandom});
  endfunction

  // ---------------- tests ----------------
  task automatic test_reset_state;
    // reset config: center at origin, zero radius, full flux window
    send_source(24'h000000, 24'h000000, 48'h0);
    send_source(24'h000000, 24'h000000, FLUX_ALL);
    send_source(24'h000001, 24'h000000, 48'h1234);
    send_source(24'h800000, 24'h000000, 48'h1);
  endtask

  task automatic test_extremes;
    set_search(24'h123456, 24'h100000, 24'h080000, 48'h0, FLUX_ALL);
    send_source(24'h123456, 24'h100000, 48'h55);   // exactly at center
    send_source(24'hffffff, DEC_MAX, 48'h0);
    send_source(24'h000000, DEC_MIN, FLUX_ALL);
    send_source(24'h923456, 24'hf00000, 48'h7);    // antipode
    send_source(24'h555555, 24'h7fffff, 48'h9);    // declination past a quarter turn
    send_source(24'haaaaaa, 24'h800000, 48'h9);
    send_source(24'h3fffff, 24'hbfffff, 48'h9);
  endtask

  task automatic test_flux_window;
    set_search(24'h000000, 24'h000000, 24'h200000, 48'd100, 48'd200);
    send_source(24'h010000, 24'h010000, 48'd99);
    send_source(24'h010000, 24'h010000, 48'd100);
    send_source(24'h010000, 24'h010000, 48'd200);
    send_source(24'h010000, 24'h010000, 48'd201);
    send_source(24'h010000, 24'h010000, FLUX_ALL);
    // inverted window rejects everything
    set_search(24'h000000, 24'h000000, 24'h200000, 48'd500, 48'd400);
    send_source(24'h000000, 24'h000000, 48'd450);
    send_source(24'h000000, 24'h000000, 48'd400);
    send_source(24'h000000, 24'h000000, 48'd500);
  endtask

  task automatic test_wide_radius;
    // radius past half a turn: every flux-accepted source matches
    set_search(24'h400000, DEC_MIN, 24'hffffff, 48'h0, FLUX_ALL);
    send_source(24'hc00000, DEC_MAX, 48'h1);
    send_source(24'h000000, 24'h000000, 48'h1);
    // unknown register indexes leave the settings alone
    drain();
    write_reg(scff_pkg::cfg_idx_t'(5), FLUX_ALL);
    write_reg(scff_pkg::cfg_idx_t'(6), 48'h0);
    write_reg(scff_pkg::cfg_idx_t'(7), 48'h1);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_source(24'h000000, 24'h000000, 48'h1);
  endtask

  task automatic test_random_search;
    logic [23:0] rad;
    logic [47:0] lo, hi;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: rad = 24'h0;
        1: rad = 24'h800000;
        2: rad = 24'hffffff;
        default: rad = 24'($urandom_range(0, 8388608));
      endcase
      lo = (ph % 3 == 0) ? 48'h0 : 48'({$urandom, $urandom});
      hi = (ph % 3 == 0) ? FLUX_ALL : 48'({$urandom, $urandom});
      if (ph % 3 == 1 && lo > hi) {lo, hi} = {hi, lo};
      set_search(24'($urandom), (ph == 2) ? DEC_MAX : (ph == 5) ? DEC_MIN : rand_dec(),
                 rad, lo, hi);
      for (int n = 0; n < 110; n++) begin
        // cluster some sources near the center so the cone test sees both outcomes
        if ($urandom_range(0, 2) == 0)
          send_source(ctr_ra + 24'($urandom_range(0, 65535)) - 24'd32768,
                      ctr_dec + 24'($urandom_range(0, 65535)) - 24'd32768, rand_flux());
        else
          send_source(24'($urandom), rand_dec(), rand_flux());
      end
    end
  endtask

  task automatic test_backpressure;
    set_search(24'($urandom), rand_dec(), 24'h300000, 48'h0, FLUX_ALL);
    hold_left = 400;
    for (int n = 0; n < 150; n++) send_source(24'($urandom), rand_dec(), rand_flux());
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = scff_pkg::REG_CENTER_RA;
    cfg_data          = '0;
    in_req.valid      = 1'b0;
    in_req.source_ra  = '0;
    in_req.source_dec = '0;
    in_req.peak_flux  = '0;
    out_res.ready     = 1'b0;
    errors     = 0;
    cycles     = 0;
    burst_left = 0;
    hold_left  = 0;
    ctr_ra  = '0;
    ctr_dec = '0;
    radius  = '0;
    flux_lo = '0;
    flux_hi = FLUX_ALL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extremes();
    test_flux_window();
    test_wide_radius();
    test_random_search();
    test_backpressure();

    in_req.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
